/* src/rc4_pkg.sv */
// Shared constants and types of the RC4 stream cipher engine.
package rc4_pkg;

  localparam int TABLE_SIZE      = 256;
  localparam int IDX_W           = 8;
  localparam int KEY_MAX_DEFAULT = 256;
  localparam int KEY_LEN_W       = 9;
  localparam int SKIP_W          = 16;
  localparam int KEY_LEN_RESET   = 16;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_SCHEDULE = 2'd1,
    CMD_DISCARD  = 2'd2,
    CMD_CRYPT    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_RD,
    ST_STEP_J,
    ST_STEP_SWAP,
    ST_FIN
  } state_t;

endpackage

/* src/rc4_stream_cipher.sv */
// RC4 stream cipher engine with its permutation table and key store in memories.
//
// Channel  Direction  Payload
// s_axis   in         tuser: command; tdata: data_byte, key_index, skip_count
// m_axis   out        tdata: out_byte
// config   in         key_length_we, key_length_wdata (key_length)
//
// A keystream step reads S[i], reads S[j], then writes S[i]; the second swap write, of S[j],
// overlaps the first read of the next step on the table memory.
// Reset is synchronous; the table reads as identity through per-entry valid bits.
// A crypt result waits in an output register and holds the engine only when it is full.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,     // data_byte, key_index, skip_count
  input  logic [1:0]           s_axis_tuser,     // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,     // out_byte
  input  logic                 key_length_we,
  input  logic [KEY_LEN_W-1:0] key_length_wdata
);

  localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam logic [KEY_LEN_W-1:0] KEY_MAX_L = KEY_LEN_W'(KEY_MAX);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  state_t state, state_next;

  logic [IDX_W-1:0] perm_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] perm_valid;
  logic [7:0] key_mem [KEY_MAX];

  logic [KEY_LEN_W-1:0] key_len;
  logic [KEY_LEN_W-1:0] klen;
  logic [KW-1:0] kpos;
  logic [7:0] key_rd;

  cmd_t mode;
  logic [IDX_W-1:0] i, j, n, pos, pend_addr, pend_data, t_q;
  logic [7:0] data_q;
  logic [SKIP_W-1:0] count;

  logic [IDX_W-1:0] rd_a_data, rd_a_addr, rd_b_data, rd_b_addr;
  logic rd_a_ok, rd_b_ok;
  logic [IDX_W-1:0] sval_a, sval_b;

  logic perm_we, valid_clear;
  logic [IDX_W-1:0] perm_waddr, perm_wdata, raddr_a, raddr_b;

  cmd_t cmd_in;
  logic [SKIP_W-1:0] skip_in;
  logic [7:0] key_idx_in;
  logic accept, adv_start, sched_start, out_free, fin_done, out_load, step_last;
  logic sched_now;
  logic [IDX_W-1:0] pos_start, key_term, jn, ks;
  logic [KEY_LEN_W-1:0] kpos_inc;

  assign cmd_in     = cmd_t'(s_axis_tuser);
  assign skip_in    = s_axis_tdata[31:16];
  assign key_idx_in = s_axis_tdata[15:8];
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign adv_start  = accept && (cmd_in == CMD_CRYPT ||
                                (cmd_in == CMD_DISCARD && skip_in != '0));
  assign sched_start = accept && cmd_in == CMD_SCHEDULE;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign fin_done = (mode != CMD_CRYPT) || out_free;
  assign out_load = (state == ST_FIN) && (mode == CMD_CRYPT) && out_free;
  assign s_axis_tready = (state == ST_IDLE) || (state == ST_FIN && fin_done);

  assign sval_a = rd_a_ok ? rd_a_data : rd_a_addr;
  assign sval_b = rd_b_ok ? rd_b_data : rd_b_addr;

  assign sched_now = (state == ST_STEP_RD) && (mode == CMD_SCHEDULE);
  assign pos_start = sched_now ? n : i + 1'b1;
  assign key_term  = (mode == CMD_SCHEDULE) ? key_rd : '0;
  assign jn        = j + sval_a + key_term;
  assign ks        = (t_q == pend_addr) ? pend_data : sval_b;
  assign kpos_inc  = KEY_LEN_W'(kpos) + 1'b1;

  always_comb begin
    case (mode)
      CMD_SCHEDULE: step_last = (n == LAST_IDX);
      CMD_DISCARD:  step_last = (count == '0);
      default:      step_last = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sched_start) begin
          state_next = ST_STEP_RD;
        end else if (adv_start) begin
          state_next = ST_STEP_J;
        end
      end
      ST_STEP_RD:   state_next = ST_STEP_J;
      ST_STEP_J:    state_next = ST_STEP_SWAP;
      ST_STEP_SWAP: state_next = step_last ? ST_FIN : ST_STEP_RD;
      ST_FIN: begin
        if (fin_done) begin
          if (sched_start) begin
            state_next = ST_STEP_RD;
          end else if (adv_start) begin
            state_next = ST_STEP_J;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    perm_we     = 1'b0;
    perm_waddr  = pend_addr;
    perm_wdata  = pend_data;
    raddr_a     = pos_start;
    raddr_b     = '0;
    valid_clear = sched_start;
    case (state)
      ST_STEP_RD: perm_we = !(sched_now && n == '0);
      ST_STEP_J:  raddr_a = jn;
      ST_STEP_SWAP: begin
        perm_we    = 1'b1;
        perm_waddr = pos;
        perm_wdata = sval_a;
        raddr_b    = pend_data + sval_a;
      end
      ST_FIN: begin
        perm_we = !sched_start;
        raddr_b = t_q;
      end
      default:    perm_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    rd_a_addr <= raddr_a;
    rd_b_addr <= raddr_b;
    if (perm_we && perm_waddr == raddr_a) begin
      rd_a_data <= perm_wdata;
      rd_a_ok   <= 1'b1;
    end else begin
      rd_a_data <= perm_mem[raddr_a];
      rd_a_ok   <= perm_valid[raddr_a];
    end
    if (perm_we && perm_waddr == raddr_b) begin
      rd_b_data <= perm_wdata;
      rd_b_ok   <= 1'b1;
    end else begin
      rd_b_data <= perm_mem[raddr_b];
      rd_b_ok   <= perm_valid[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || valid_clear) begin
      perm_valid <= '0;
    end else if (perm_we) begin
      perm_valid[perm_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd_in == CMD_LOAD && {1'b0, key_idx_in} < KEY_MAX_L) begin
      key_mem[key_idx_in[KW-1:0]] <= s_axis_tdata[7:0];
    end
    key_rd <= key_mem[kpos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= KEY_LEN_W'(KEY_LEN_RESET);
    end else if (key_length_we) begin
      key_len <= key_length_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= CMD_LOAD;
      i             <= '0;
      j             <= '0;
      n             <= '0;
      kpos          <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        mode   <= cmd_in;
        data_q <= s_axis_tdata[7:0];
        count  <= skip_in - 1'b1;
      end
      if (sched_start) begin
        i    <= '0;
        j    <= '0;
        n    <= '0;
        kpos <= '0;
        if (key_len == '0) begin
          klen <= KEY_LEN_W'(1);
        end else if (key_len > KEY_MAX_L) begin
          klen <= KEY_MAX_L;
        end else begin
          klen <= key_len;
        end
      end
      if ((state == ST_STEP_RD) || adv_start) begin
        pos <= pos_start;
        if (!sched_now) begin
          i <= i + 1'b1;
        end
      end
      if (state == ST_STEP_J) begin
        j         <= jn;
        pend_addr <= jn;
        pend_data <= sval_a;
        if (mode == CMD_SCHEDULE) begin
          kpos <= (kpos_inc == klen) ? '0 : kpos + 1'b1;
        end
      end
      if (state == ST_STEP_SWAP) begin
        t_q <= pend_data + sval_a;
        if (mode == CMD_SCHEDULE) begin
          n <= n + 1'b1;
          if (step_last) begin
            j <= '0;
          end
        end else if (mode == CMD_DISCARD && !step_last) begin
          count <= count - 1'b1;
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= ks ^ data_q;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_STEP_J) |-> !perm_we)
    else $error("table written outside a swap cycle");

  a_ready_states: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == ST_IDLE || state == ST_FIN))
    else $error("input ready while a step is in progress");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_FIN && $past(mode) == CMD_CRYPT))
    else $error("result word without a finished crypt step");

  a_sched_clears: assert property (@(posedge clk) disable iff (rst)
    sched_start |=> (perm_valid == '0 && state == ST_STEP_RD))
    else $error("key schedule did not restart from identity");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the RC4 stream cipher engine with a predicting scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rc4_pkg::*;

  localparam int STALL_LIMIT    = 700000;
  localparam int SETTLE_CYCLES  = 800;
  localparam int WORDS_PER_PASS = 230;

  class keystream_scoreboard;
    bit [7:0] perm [TABLE_SIZE];
    bit [7:0] key_bytes [TABLE_SIZE];
    bit [7:0] idx_i;
    bit [7:0] idx_j;
    bit [KEY_LEN_W-1:0] key_len;
    bit [7:0] expected_bytes [$];
    int errors;
    int bytes_checked;
    int words_by_cmd [4];

    function new();
      for (int n = 0; n < TABLE_SIZE; n++) begin
        perm[n] = 8'(n);
        key_bytes[n] = 8'h00;
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
      key_len = KEY_LEN_W'(KEY_LEN_RESET);
    endfunction

    function int used_key_len();
      if (key_len == 0) return 1;
      if (key_len > TABLE_SIZE) return TABLE_SIZE;
      return int'(key_len);
    endfunction

    function void set_key_length(bit [KEY_LEN_W-1:0] value);
      key_len = value;
    endfunction

    function void swap_entries(bit [7:0] a, bit [7:0] b);
      bit [7:0] held;
      held = perm[a];
      perm[a] = perm[b];
      perm[b] = held;
    endfunction

    function void step_keystream();
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      swap_entries(idx_i, idx_j);
    endfunction

    function void note_word(cmd_t cmd, bit [7:0] data, bit [7:0] kidx, bit [15:0] skip);
      bit [7:0] j;
      bit [7:0] sum;
      int len;
      words_by_cmd[cmd]++;
      case (cmd)
        CMD_LOAD: begin
          key_bytes[kidx] = data;
        end
        CMD_SCHEDULE: begin
          len = used_key_len();
          j = 8'd0;
          idx_i = 8'd0;
          idx_j = 8'd0;
          for (int n = 0; n < TABLE_SIZE; n++) perm[n] = 8'(n);
          for (int n = 0; n < TABLE_SIZE; n++) begin
            j = j + perm[n] + key_bytes[n % len];
            swap_entries(8'(n), j);
          end
        end
        CMD_DISCARD: begin
          for (int n = 0; n < int'(skip); n++) step_keystream();
        end
        default: begin
          step_keystream();
          sum = perm[idx_i] + perm[idx_j];
          expected_bytes.push_back(perm[sum] ^ data);
        end
      endcase
    endfunction

    function void check_byte(bit [7:0] got);
      bit [7:0] want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: out_byte %02h arrived with no crypt word pending", $time, got);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (got !== want) begin
          $display("%0t: out_byte mismatch, expected %02h, actual %02h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int expected_count();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;
  logic                 key_length_we;
  logic [KEY_LEN_W-1:0] key_length_wdata;

  keystream_scoreboard board;
  bit key_loaded [TABLE_SIZE];
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;
  logic [KEY_LEN_W-1:0] key_len_plan [6];

  rc4_stream_cipher dut (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .key_length_we    (key_length_we),
    .key_length_wdata (key_length_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_byte(m_axis_tdata);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_word(input cmd_t cmd, input logic [7:0] data, input logic [7:0] kidx,
                           input logic [15:0] skip);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {skip, kidx, data};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    board.note_word(cmd, data, kidx, skip);
    if (cmd == CMD_LOAD) key_loaded[kidx] = 1'b1;
    @(negedge clk);
  endtask

  task automatic write_key_length(input logic [KEY_LEN_W-1:0] value);
    key_length_we    <= 1'b1;
    key_length_wdata <= value;
    @(posedge clk);
    board.set_key_length(value);
    @(negedge clk);
    key_length_we <= 1'b0;
  endtask

  // Every key byte that the schedule will read is loaded first.
  task automatic schedule_key();
    for (int n = 0; n < board.used_key_len(); n++) begin
      if (!key_loaded[n]) send_word(CMD_LOAD, 8'($urandom), 8'(n), 16'($urandom));
    end
    send_word(CMD_SCHEDULE, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.expected_count() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_word();
    int roll;
    int pick;
    logic [7:0] kidx;
    logic [15:0] skip;
    roll = $urandom_range(99);
    if (roll < 12) begin
      if ($urandom_range(3) == 0) kidx = 8'($urandom);
      else kidx = 8'($urandom_range(board.used_key_len() - 1));
      send_word(CMD_LOAD, 8'($urandom), kidx, 16'($urandom));
    end else if (roll < 16) begin
      schedule_key();
    end else if (roll < 26) begin
      pick = $urandom_range(99);
      if (pick < 70) skip = 16'($urandom_range(8));
      else if (pick < 95) skip = 16'($urandom_range(300, 9));
      else skip = 16'($urandom_range(2000, 301));
      send_word(CMD_DISCARD, 8'($urandom), 8'($urandom), skip);
    end else begin
      send_word(CMD_CRYPT, 8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    board = new();
    stall_cycles = 0;
    send_idle_pct = 7;
    recv_idle_pct = 84;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_LOAD;
    key_length_we = 1'b0;
    key_length_wdata = '0;
    key_len_plan[0] = 9'd1;
    key_len_plan[1] = 9'd256;
    key_len_plan[2] = 9'd0;
    key_len_plan[3] = 9'd511;
    key_len_plan[4] = 9'd5;
    key_len_plan[5] = 9'($urandom_range(255, 2));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The reset key length of sixteen is exercised first, with the field extremes.
    send_word(CMD_LOAD, 8'hFF, 8'd255, 16'h0000);
    for (int n = 0; n < 16; n++) begin
      send_word(CMD_LOAD, (n == 0) ? 8'h00 : (n == 15) ? 8'hFF : 8'($urandom), 8'(n),
                16'hFFFF);
    end
    send_word(CMD_SCHEDULE, 8'h00, 8'h00, 16'h0000);
    send_word(CMD_CRYPT, 8'h00, 8'h00, 16'h0000);
    send_word(CMD_CRYPT, 8'hFF, 8'hFF, 16'hFFFF);
    send_word(CMD_DISCARD, 8'h00, 8'h00, 16'h0000);
    send_word(CMD_CRYPT, 8'h5A, 8'h00, 16'h0000);
    send_word(CMD_DISCARD, 8'h00, 8'h00, 16'h0001);
    send_word(CMD_DISCARD, 8'hFF, 8'hFF, 16'hFFFF);
    send_word(CMD_CRYPT, 8'hA5, 8'h00, 16'h0000);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 84;
        recv_idle_pct = 7;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_key_length(key_len_plan[p]);
      schedule_key();
      repeat (WORDS_PER_PASS) random_word();
      send_word(CMD_CRYPT, 8'($urandom), 8'($urandom), 16'($urandom));
      drain();
    end

    $display("Sent %0d loads, %0d key schedules, %0d discards and %0d crypt words.",
             board.words_by_cmd[CMD_LOAD], board.words_by_cmd[CMD_SCHEDULE],
             board.words_by_cmd[CMD_DISCARD], board.words_by_cmd[CMD_CRYPT]);
    $display("Checked %0d output bytes over key lengths 16, 1, 256, 0, 511, 5 and %0d.",
             board.bytes_checked, key_len_plan[5]);
    if (board.errors == 0 && board.expected_count() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
